>>> rtl/assert_macros.svh
// Assertion macros used by the top-level RTL file of the peer wire framer.
// No dependencies; included inside a module body.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that an expression holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk_sig, rst_sig, expr) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) (expr)) \
    else $error("assertion failed");

// Checks that a condition implies a consequence in the same cycle.
`define ASSERT_IMPLIES(label, clk_sig, rst_sig, cond, cons) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) (cond) |-> (cons)) \
    else $error("assertion failed");

// Checks that a condition implies a consequence in the following cycle.
`define ASSERT_NEXT(label, clk_sig, rst_sig, cond, cons) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) (cond) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> rtl/pwmf_pkg.sv
// Types and constants of the peer wire message framer.
// No dependencies; imported by the parser and the top level.
package pwmf_pkg;

  typedef enum logic [3:0] {
    KIND_PREFIX    = 4'd0,
    KIND_INFOHASH  = 4'd1,
    KIND_PEERID    = 4'd2,
    KIND_LENGTH    = 4'd3,
    KIND_KEEPALIVE = 4'd4,
    KIND_MSGID     = 4'd5,
    KIND_PIECEMETA = 4'd6,
    KIND_BODY      = 4'd7,
    KIND_ERROR     = 4'd8
  } kind_t;

  typedef enum logic [1:0] {
    CAUSE_NONE   = 2'd0,
    CAUSE_PREFIX = 2'd1,
    CAUSE_FRAME  = 2'd2
  } cause_t;

  typedef enum logic [7:0] {
    PH_PREFIX = 8'b0000_0001,
    PH_INFO   = 8'b0000_0010,
    PH_PEERID = 8'b0000_0100,
    PH_LEN    = 8'b0000_1000,
    PH_HEAD   = 8'b0001_0000,
    PH_META   = 8'b0010_0000,
    PH_BODY   = 8'b0100_0000,
    PH_ERR    = 8'b1000_0000
  } phase_t;

  localparam logic [7:0] ID_CHOKE          = 8'd0;
  localparam logic [7:0] ID_UNCHOKE        = 8'd1;
  localparam logic [7:0] ID_INTERESTED     = 8'd2;
  localparam logic [7:0] ID_NOT_INTERESTED = 8'd3;
  localparam logic [7:0] ID_HAVE           = 8'd4;
  localparam logic [7:0] ID_BITFIELD       = 8'd5;
  localparam logic [7:0] ID_REQUEST        = 8'd6;
  localparam logic [7:0] ID_PIECE          = 8'd7;
  localparam logic [7:0] ID_CANCEL         = 8'd8;

  localparam logic [31:0] HS_FIELD_LEN  = 32'd20;
  localparam logic [31:0] LEN_BYTES     = 32'd4;
  localparam logic [31:0] META_BYTES    = 32'd8;
  localparam logic [31:0] LEN_SHORT     = 32'd1;
  localparam logic [31:0] LEN_HAVE      = 32'd5;
  localparam logic [31:0] LEN_REQUEST   = 32'd13;
  localparam logic [31:0] LEN_PIECE_MIN = 32'd9;

  localparam logic [2:0] ADDR_NUM_PIECES    = 3'd0;
  localparam logic [2:0] ADDR_MAX_BLOCK_LEN = 3'd4;

  typedef struct packed {
    logic [20:0] num_pieces;
    logic [17:0] max_block_len;
  } cfg_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  data_byte;
    logic [7:0]  msg_id;
    logic [31:0] msg_length;
    logic [31:0] piece_index;
    logic [31:0] piece_begin;
    logic        end_of_message;
    cause_t      error_cause;
  } res_t;

  // Handshake prefix: length byte 19, then the protocol name.
  function automatic logic [7:0] hs_byte(input logic [4:0] pos);
    logic [7:0] b;
    unique case (pos)
      5'd0:  b = 8'h13;
      5'd1:  b = "B";
      5'd2:  b = "i";
      5'd3:  b = "t";
      5'd4:  b = "T";
      5'd5:  b = "o";
      5'd6:  b = "r";
      5'd7:  b = "r";
      5'd8:  b = "e";
      5'd9:  b = "n";
      5'd10: b = "t";
      5'd11: b = " ";
      5'd12: b = "p";
      5'd13: b = "r";
      5'd14: b = "o";
      5'd15: b = "t";
      5'd16: b = "o";
      5'd17: b = "c";
      5'd18: b = "o";
      5'd19: b = "l";
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

>>> rtl/pwmf_parse.sv
// Byte parser of the peer wire framer: holds the framing state and forms one
// result per accepted byte. Depends on pwmf_pkg.
module pwmf_parse
  import pwmf_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  logic [7:0] rx_byte,
  input  cfg_t       cfg,
  output res_t       res
);

  phase_t      phase, phase_next;
  logic [31:0] bytes_left, bytes_left_next;
  logic [31:0] cur_length, cur_length_next;
  logic [7:0]  cur_id, cur_id_next;
  logic [31:0] index_reg, index_reg_next;
  logic [31:0] begin_reg, begin_reg_next;
  cause_t      cause, cause_next;

  logic [4:0]  pos;
  logic        last;
  logic [31:0] len_shift;
  logic [21:0] np_sum;
  logic [31:0] bitfield_len;
  logic [31:0] piece_max;
  logic        len_ok;
  kind_t       kind;
  logic        eom;

  assign pos          = 5'd20 - bytes_left[4:0];
  assign last         = (bytes_left <= 32'd1);
  assign len_shift    = {cur_length[23:0], rx_byte};
  assign np_sum       = {1'b0, cfg.num_pieces} + 22'd7;
  assign bitfield_len = {13'd0, np_sum[21:3]} + 32'd1;
  assign piece_max    = {14'd0, cfg.max_block_len} + LEN_PIECE_MIN;

  always_comb begin
    unique case (rx_byte)
      ID_CHOKE, ID_UNCHOKE, ID_INTERESTED, ID_NOT_INTERESTED:
        len_ok = (cur_length == LEN_SHORT);
      ID_HAVE:              len_ok = (cur_length == LEN_HAVE);
      ID_BITFIELD:          len_ok = (cur_length == bitfield_len);
      ID_REQUEST, ID_CANCEL: len_ok = (cur_length == LEN_REQUEST);
      ID_PIECE:
        len_ok = (cur_length >= LEN_PIECE_MIN) && (cur_length <= piece_max);
      default:              len_ok = 1'b0;
    endcase
  end

  always_comb begin
    phase_next      = phase;
    bytes_left_next = bytes_left;
    cur_length_next = cur_length;
    cur_id_next     = cur_id;
    index_reg_next  = index_reg;
    begin_reg_next  = begin_reg;
    cause_next      = cause;
    kind            = KIND_ERROR;
    eom             = 1'b0;
    unique case (phase)
      PH_PREFIX: begin
        if (rx_byte != hs_byte(pos)) begin
          phase_next = PH_ERR;
          cause_next = CAUSE_PREFIX;
        end else begin
          kind = KIND_PREFIX;
          if (last) begin
            phase_next      = PH_INFO;
            bytes_left_next = HS_FIELD_LEN;
          end else begin
            bytes_left_next = bytes_left - 32'd1;
          end
        end
      end
      PH_INFO: begin
        kind = KIND_INFOHASH;
        if (last) begin
          phase_next      = PH_PEERID;
          bytes_left_next = HS_FIELD_LEN;
        end else begin
          bytes_left_next = bytes_left - 32'd1;
        end
      end
      PH_PEERID: begin
        kind = KIND_PEERID;
        if (last) begin
          eom             = 1'b1;
          phase_next      = PH_LEN;
          bytes_left_next = LEN_BYTES;
          cur_length_next = 32'd0;
        end else begin
          bytes_left_next = bytes_left - 32'd1;
        end
      end
      PH_LEN: begin
        kind            = KIND_LENGTH;
        cur_length_next = len_shift;
        if (last) begin
          if (len_shift == 32'd0) begin
            kind            = KIND_KEEPALIVE;
            eom             = 1'b1;
            bytes_left_next = LEN_BYTES;
          end else begin
            phase_next      = PH_HEAD;
            bytes_left_next = 32'd1;
          end
        end else begin
          bytes_left_next = bytes_left - 32'd1;
        end
      end
      PH_HEAD: begin
        cur_id_next = rx_byte;
        if (!len_ok) begin
          phase_next = PH_ERR;
          cause_next = CAUSE_FRAME;
        end else begin
          kind = KIND_MSGID;
          if (cur_length == LEN_SHORT) begin
            eom             = 1'b1;
            phase_next      = PH_LEN;
            bytes_left_next = LEN_BYTES;
          end else if (rx_byte == ID_PIECE) begin
            phase_next      = PH_META;
            bytes_left_next = META_BYTES;
          end else begin
            phase_next      = PH_BODY;
            bytes_left_next = cur_length - 32'd1;
          end
        end
      end
      PH_META: begin
        kind = KIND_PIECEMETA;
        if (bytes_left > 32'd4) begin
          index_reg_next = {index_reg[23:0], rx_byte};
        end else begin
          begin_reg_next = {begin_reg[23:0], rx_byte};
        end
        if (last) begin
          if (cur_length <= LEN_PIECE_MIN) begin
            eom             = 1'b1;
            phase_next      = PH_LEN;
            bytes_left_next = LEN_BYTES;
          end else begin
            phase_next      = PH_BODY;
            bytes_left_next = cur_length - LEN_PIECE_MIN;
          end
        end else begin
          bytes_left_next = bytes_left - 32'd1;
        end
      end
      PH_BODY: begin
        kind = KIND_BODY;
        if (last) begin
          eom             = 1'b1;
          phase_next      = PH_LEN;
          bytes_left_next = LEN_BYTES;
        end else begin
          bytes_left_next = bytes_left - 32'd1;
        end
      end
      PH_ERR: begin
        kind = KIND_ERROR;
      end
      default: begin
        kind = KIND_ERROR;
      end
    endcase
  end

  always_comb begin
    res.kind           = kind;
    res.data_byte      = rx_byte;
    res.msg_id         = cur_id_next;
    res.msg_length     = cur_length_next;
    res.piece_index    = index_reg_next;
    res.piece_begin    = begin_reg_next;
    res.end_of_message = eom;
    res.error_cause    = (phase_next == PH_ERR) ? cause_next : CAUSE_NONE;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_PREFIX;
      bytes_left <= HS_FIELD_LEN;
      cur_length <= 32'd0;
      cur_id     <= 8'd0;
      index_reg  <= 32'd0;
      begin_reg  <= 32'd0;
      cause      <= CAUSE_NONE;
    end else if (step) begin
      phase      <= phase_next;
      bytes_left <= bytes_left_next;
      cur_length <= cur_length_next;
      cur_id     <= cur_id_next;
      index_reg  <= index_reg_next;
      begin_reg  <= begin_reg_next;
      cause      <= cause_next;
    end
  end

endmodule

>>> rtl/peer_wire_message_framer.sv
// Top level of the peer wire message framer: register port, parser and
// output register with skid stage. Depends on pwmf_pkg, pwmf_parse, assert_macros.svh.
//
// The framer takes one received byte per clock while in_stall is low and returns
// one result per byte through the output register; the combinational parse stage
// before the output register sets that rate. A skid register behind the output
// register keeps a second result, so in_stall rises only when both are full. The
// user must write registers num_pieces and max_block_len through the register port
// while no byte is in flight; the framer itself does not enforce this.
module peer_wire_message_framer
  import pwmf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  kind,
  output logic [7:0]  data_byte,
  output logic [7:0]  msg_id,
  output logic [31:0] msg_length,
  output logic [31:0] piece_index,
  output logic [31:0] piece_begin,
  output logic        end_of_message,
  output logic [1:0]  error_cause
);

  cfg_t cfg;
  res_t res;
  res_t out_q;
  res_t skid_q;
  logic out_v;
  logic skid_v;
  logic in_acc;
  logic out_acc;
  logic wr_en;
  logic err_match;
  logic eom_kind_ok;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.num_pieces    <= 21'd1;
      cfg.max_block_len <= 18'd16384;
    end else if (wr_en) begin
      if (paddr[2] == ADDR_NUM_PIECES[2]) begin
        cfg.num_pieces <= pwdata[20:0];
      end else begin
        cfg.max_block_len <= pwdata[17:0];
      end
    end
  end

  assign prdata = (paddr[2] == ADDR_MAX_BLOCK_LEN[2]) ? {14'd0, cfg.max_block_len}
                                                      : {11'd0, cfg.num_pieces};

  assign in_stall = skid_v;
  assign in_acc   = in_valid && !skid_v;
  assign out_acc  = out_v && !out_stall;

  pwmf_parse u_parse (
    .clk     (clk),
    .rst     (rst),
    .step    (in_acc),
    .rx_byte (rx_byte),
    .cfg     (cfg),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v  <= 1'b0;
      skid_v <= 1'b0;
    end else if (!out_v || out_acc) begin
      if (skid_v) begin
        out_v  <= 1'b1;
        skid_v <= 1'b0;
      end else begin
        out_v <= in_acc;
      end
    end else if (in_acc) begin
      skid_v <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_v || out_acc) begin
      out_q <= skid_v ? skid_q : res;
    end
    if (out_v && !out_acc && in_acc) begin
      skid_q <= res;
    end
  end

  assign out_valid      = out_v;
  assign kind           = out_q.kind;
  assign data_byte      = out_q.data_byte;
  assign msg_id         = out_q.msg_id;
  assign msg_length     = out_q.msg_length;
  assign piece_index    = out_q.piece_index;
  assign piece_begin    = out_q.piece_begin;
  assign end_of_message = out_q.end_of_message;
  assign error_cause    = out_q.error_cause;

  assign err_match   = ((kind == KIND_ERROR) == (error_cause != CAUSE_NONE));
  assign eom_kind_ok = (kind == KIND_PEERID) || (kind == KIND_KEEPALIVE) ||
                       (kind == KIND_MSGID) || (kind == KIND_PIECEMETA) ||
                       (kind == KIND_BODY);

`include "assert_macros.svh"

  `ASSERT_IMPLIES(a_skid_behind_out, clk, rst, skid_v, out_v)
  `ASSERT_IMPLIES(a_err_has_cause, clk, rst, out_v, err_match)
  `ASSERT_IMPLIES(a_eom_kind, clk, rst, out_v && end_of_message, eom_kind_ok)
  `ASSERT_NEXT(a_err_sticky, clk, rst, out_acc && kind == KIND_ERROR, !out_v || kind == KIND_ERROR)

endmodule

>>> tb/sv/tb_peer_wire_message_framer.sv
// Self-checking testbench for peer_wire_message_framer: handshake, framed messages,
// register settings, closing framing or prefix fault, random gaps and output stalls.
// Depends on pwmf_pkg and the framer RTL; a small scoreboard class predicts each result.
import pwmf_pkg::*;

localparam logic [159:0] HANDSHAKE_PREFIX = {8'h13, "BitTorrent protocol"};

function automatic logic [7:0] prefix_byte(input int pos);
  logic [159:0] s;
  s = HANDSHAKE_PREFIX << (8 * pos);
  return s[159:152];
endfunction

class frame_predictor;
  logic [20:0] num_pieces;
  logic [17:0] max_block_len;
  phase_t      ph;
  logic [31:0] left;
  logic [31:0] length;
  logic [31:0] index_acc;
  logic [31:0] begin_acc;
  logic [7:0]  id;
  bit          err;
  cause_t      cause;
  res_t        pending[$];
  int          mismatches;

  function new();
    num_pieces    = 21'd1;
    max_block_len = 18'd16384;
    ph            = PH_PREFIX;
    left          = HS_FIELD_LEN;
    length        = 32'd0;
    index_acc     = 32'd0;
    begin_acc     = 32'd0;
    id            = 8'd0;
    err           = 1'b0;
    cause         = CAUSE_NONE;
    mismatches    = 0;
  endfunction

  function void set_reg(input logic [2:0] addr, input logic [31:0] value);
    if (addr == ADDR_NUM_PIECES) begin
      num_pieces = value[20:0];
    end else if (addr == ADDR_MAX_BLOCK_LEN) begin
      max_block_len = value[17:0];
    end
  endfunction

  function bit length_fits();
    case (id)
      ID_CHOKE, ID_UNCHOKE, ID_INTERESTED, ID_NOT_INTERESTED: return length == LEN_SHORT;
      ID_HAVE: return length == LEN_HAVE;
      ID_BITFIELD: return length == ((32'(num_pieces) + 32'd7) >> 3) + 32'd1;
      ID_REQUEST, ID_CANCEL: return length == LEN_REQUEST;
      ID_PIECE: return length >= LEN_PIECE_MIN &&
                       length <= 32'(max_block_len) + LEN_PIECE_MIN;
      default: return 1'b0;
    endcase
  endfunction

  function void flag(input cause_t c);
    err   = 1'b1;
    cause = c;
    ph    = PH_ERR;
  endfunction

  function void take_byte(input logic [7:0] b);
    res_t  r;
    kind_t k;
    logic  eom;
    k   = KIND_ERROR;
    eom = 1'b0;
    if (!err) begin
      case (ph)
        PH_PREFIX: begin
          if (b != prefix_byte(HS_FIELD_LEN - left)) begin
            flag(CAUSE_PREFIX);
          end else begin
            k    = KIND_PREFIX;
            left = left - 32'd1;
            if (left == 32'd0) begin
              ph   = PH_INFO;
              left = HS_FIELD_LEN;
            end
          end
        end
        PH_INFO: begin
          k = KIND_INFOHASH;
          if (left <= 32'd1) begin
            ph   = PH_PEERID;
            left = HS_FIELD_LEN;
          end else begin
            left = left - 32'd1;
          end
        end
        PH_PEERID: begin
          k = KIND_PEERID;
          if (left <= 32'd1) begin
            eom    = 1'b1;
            ph     = PH_LEN;
            left   = LEN_BYTES;
            length = 32'd0;
          end else begin
            left = left - 32'd1;
          end
        end
        PH_LEN: begin
          k      = KIND_LENGTH;
          length = {length[23:0], b};
          if (left <= 32'd1) begin
            if (length == 32'd0) begin
              k    = KIND_KEEPALIVE;
              eom  = 1'b1;
              left = LEN_BYTES;
            end else begin
              ph   = PH_HEAD;
              left = 32'd1;
            end
          end else begin
            left = left - 32'd1;
          end
        end
        PH_HEAD: begin
          id = b;
          if (!length_fits()) begin
            flag(CAUSE_FRAME);
          end else begin
            k = KIND_MSGID;
            if (length == LEN_SHORT) begin
              eom  = 1'b1;
              ph   = PH_LEN;
              left = LEN_BYTES;
            end else if (id == ID_PIECE) begin
              ph   = PH_META;
              left = META_BYTES;
            end else begin
              ph   = PH_BODY;
              left = length - 32'd1;
            end
          end
        end
        PH_META: begin
          k = KIND_PIECEMETA;
          if (left > 32'd4) begin
            index_acc = {index_acc[23:0], b};
          end else begin
            begin_acc = {begin_acc[23:0], b};
          end
          if (left <= 32'd1) begin
            if (length <= LEN_PIECE_MIN) begin
              eom  = 1'b1;
              ph   = PH_LEN;
              left = LEN_BYTES;
            end else begin
              ph   = PH_BODY;
              left = length - LEN_PIECE_MIN;
            end
          end else begin
            left = left - 32'd1;
          end
        end
        PH_BODY: begin
          k = KIND_BODY;
          if (left <= 32'd1) begin
            eom  = 1'b1;
            ph   = PH_LEN;
            left = LEN_BYTES;
          end else begin
            left = left - 32'd1;
          end
        end
        default: ;
      endcase
    end
    if (err) begin
      k   = KIND_ERROR;
      eom = 1'b0;
    end
    r.kind           = k;
    r.data_byte      = b;
    r.msg_id         = id;
    r.msg_length     = length;
    r.piece_index    = index_acc;
    r.piece_begin    = begin_acc;
    r.end_of_message = eom;
    r.error_cause    = err ? cause : CAUSE_NONE;
    pending.push_back(r);
  endfunction

  function void field_check(input string name, input logic [31:0] want,
                            input logic [31:0] got);
    if (got !== want) begin
      $display("%0t %s: expected %0h, got %0h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  function void match_result(input logic [3:0] kd, input logic [7:0] db,
                             input logic [7:0] mid, input logic [31:0] mlen,
                             input logic [31:0] pidx, input logic [31:0] pbeg,
                             input logic eom, input logic [1:0] ec);
    res_t e;
    if (pending.size() == 0) begin
      $display("%0t unexpected result: kind %0h byte %0h", $time, kd, db);
      mismatches++;
      return;
    end
    e = pending.pop_front();
    field_check("kind", 32'(e.kind), 32'(kd));
    field_check("data_byte", 32'(e.data_byte), 32'(db));
    field_check("msg_id", 32'(e.msg_id), 32'(mid));
    field_check("msg_length", e.msg_length, mlen);
    field_check("piece_index", e.piece_index, pidx);
    field_check("piece_begin", e.piece_begin, pbeg);
    field_check("end_of_message", 32'(e.end_of_message), 32'(eom));
    field_check("error_cause", 32'(e.error_cause), 32'(ec));
  endfunction
endclass

module tb_peer_wire_message_framer;
  localparam int IDLE_LIMIT = 2000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = 3'd0;
  logic [31:0] pwdata = 32'd0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  rx_byte = 8'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [3:0]  kind;
  logic [7:0]  data_byte;
  logic [7:0]  msg_id;
  logic [31:0] msg_length;
  logic [31:0] piece_index;
  logic [31:0] piece_begin;
  logic        end_of_message;
  logic [1:0]  error_cause;

  frame_predictor sb;
  bit             quiet = 1'b0;
  int             bytes_sent = 0;
  int             idle_cycles = 0;
  int             stall_hold = 0;
  int             stall_pick;
  logic [20:0]    np_cfg = 21'd1;
  logic [17:0]    mbl_cfg = 18'd16384;
  logic [31:0]    np_settings [6] = '{32'd1, 32'd0, 32'd8, 32'd9, 32'd2097151, 32'd1048576};
  logic [31:0]    mbl_settings [6] = '{32'd16384, 32'd0, 32'd1, 32'd262143, 32'd131072, 32'd5};

  peer_wire_message_framer uut (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (quiet) begin
      out_stall <= 1'b0;
      stall_hold = 0;
    end else if (stall_hold == 0) begin
      stall_pick = $urandom_range(0, 99);
      out_stall <= (stall_pick < 25);
      stall_hold = (stall_pick < 3 || stall_pick > 97) ? $urandom_range(10, 40)
                                                      : $urandom_range(1, 4);
    end else begin
      stall_hold--;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      sb.match_result(kind, data_byte, msg_id, msg_length, piece_index, piece_begin,
                      end_of_message, error_cause);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 96) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = pick_gap();
    repeat (gap) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.take_byte(b);
    bytes_sent++;
  endtask

  task automatic send_noise(input int count);
    for (int i = 0; i < count; i++) send_byte(8'($urandom));
  endtask

  task automatic send_length(input logic [31:0] n);
    for (int i = 3; i >= 0; i--) send_byte(n[8*i +: 8]);
  endtask

  task automatic send_message(input logic [7:0] id, input logic [31:0] n);
    send_length(n);
    send_byte(id);
    for (longint i = 1; i < n; i++) send_byte(8'($urandom));
  endtask

  task automatic send_legal_message();
    int          r;
    logic [31:0] bf;
    logic [31:0] n;
    r  = $urandom_range(0, 99);
    bf = ((32'(np_cfg) + 32'd7) >> 3) + 32'd1;
    if (r < 8) begin
      send_length(32'd0);
    end else if (r < 30) begin
      send_message(8'($urandom_range(0, 3)), LEN_SHORT);
    end else if (r < 40) begin
      send_message(ID_HAVE, LEN_HAVE);
    end else if (r < 52 && bf <= 32'd40) begin
      send_message(ID_BITFIELD, bf);
    end else if (r < 68) begin
      send_message($urandom_range(0, 1) ? ID_REQUEST : ID_CANCEL, LEN_REQUEST);
    end else begin
      if (mbl_cfg <= 18'd40 && $urandom_range(0, 2) == 0) begin
        n = 32'(mbl_cfg) + LEN_PIECE_MIN;
      end else begin
        n = LEN_PIECE_MIN + $urandom_range(0, mbl_cfg < 18'd24 ? 32'(mbl_cfg) : 32'd24);
      end
      send_message(ID_PIECE, n);
    end
  endtask

  task automatic write_reg(input logic [2:0] addr, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.set_reg(addr, value);
    if (addr == ADDR_NUM_PIECES) begin
      np_cfg = value[20:0];
    end else begin
      mbl_cfg = value[17:0];
    end
    @(posedge clk);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    int          pos;
    int          start;
    int          fault;
    logic [31:0] n;
    sb = new();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    write_reg(ADDR_NUM_PIECES, 32'd12);
    write_reg(ADDR_MAX_BLOCK_LEN, 32'd20);
    if ($urandom_range(0, 9) == 0) begin
      pos = $urandom_range(0, 19);
      for (int i = 0; i < pos; i++) send_byte(prefix_byte(i));
      send_byte(prefix_byte(pos) ^ 8'($urandom_range(1, 255)));
      send_noise(980);
    end else begin
      for (int i = 0; i < 20; i++) send_byte(prefix_byte(i));
      send_noise(40);
      send_length(32'd0);
      for (int i = 0; i < 4; i++) send_message(8'(i), LEN_SHORT);
      send_message(ID_HAVE, LEN_HAVE);
      send_message(ID_BITFIELD, 32'd3);
      send_message(ID_REQUEST, LEN_REQUEST);
      send_message(ID_PIECE, LEN_PIECE_MIN);
      send_message(ID_PIECE, 32'd29);
      send_message(ID_CANCEL, LEN_REQUEST);
      send_length(32'd0);

      for (int setting = 0; setting < 8; setting++) begin
        settle();
        if (setting < 6) begin
          write_reg(ADDR_NUM_PIECES, np_settings[setting]);
          write_reg(ADDR_MAX_BLOCK_LEN, mbl_settings[setting]);
        end else begin
          write_reg(ADDR_NUM_PIECES, $urandom_range(1, 300));
          write_reg(ADDR_MAX_BLOCK_LEN, $urandom_range(1, 64));
        end
        quiet = (setting == 3) || ($urandom_range(0, 3) == 0);
        start = bytes_sent;
        while (bytes_sent - start < 100) send_legal_message();
      end
      quiet = 1'b0;

      // The error is sticky, so the run closes with one framing fault and noise.
      fault = $urandom_range(0, 6);
      case (fault)
        0: begin
          n = $urandom;
          if (n == 32'd0) n = 32'd1;
          send_length(n);
          send_byte(8'($urandom_range(9, 255)));
        end
        1: begin
          n = $urandom;
          if (n < 32'd2) n = 32'd2;
          send_length(n);
          send_byte(8'($urandom_range(0, 3)));
        end
        2: begin
          send_length($urandom_range(0, 1) ? LEN_REQUEST : 32'd4);
          send_byte(ID_HAVE);
        end
        3: begin
          send_length($urandom_range(0, 1) ? LEN_REQUEST + 32'd1 : LEN_REQUEST - 32'd1);
          send_byte($urandom_range(0, 1) ? ID_REQUEST : ID_CANCEL);
        end
        4: begin
          send_length($urandom_range(1, 8));
          send_byte(ID_PIECE);
        end
        5: begin
          send_length(32'(mbl_cfg) + LEN_PIECE_MIN + 32'd1);
          send_byte(ID_PIECE);
        end
        default: begin
          settle();
          write_reg(ADDR_NUM_PIECES, 32'd2097151);
          send_length(32'd1);
          send_byte(ID_BITFIELD);
        end
      endcase
      send_noise(60);
    end
    settle();
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule

>>> files.f
+incdir+rtl
rtl/pwmf_pkg.sv
rtl/pwmf_parse.sv
rtl/peer_wire_message_framer.sv
tb/sv/tb_peer_wire_message_framer.sv
